### design/assert_macros.svh
// Assertion macros used by the checker file of this block.
// Holds macro definitions only; no other file needs to be included first.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SKV_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define SKV_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

// Next-cycle implication that also checks across reset.
`define SKV_ASSERT_NXT_ALWAYS(label, clk, ante, cons, msg) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error(msg);

`endif

### design/skv_pkg.sv
// Shared types and constants of the solar kiln vent and fan controller.
// No dependencies; every design module imports this package.
package skv_pkg;

    localparam int ADC_BITS   = 10;
    localparam int TEMP_W     = 15;
    localparam int TIME_W     = 32;
    localparam int LEVEL_W    = 10;
    localparam int HOLD_W     = 20;
    localparam int SAVE_W     = 17;
    localparam int CFG_DATA_W = 20;
    localparam int CFG_ADDR_W = 3;

    typedef logic [CFG_ADDR_W-1:0] cfg_addr_t;

    localparam cfg_addr_t CFG_BATTERY_START = 3'd0;
    localparam cfg_addr_t CFG_BATTERY_HOLD  = 3'd1;
    localparam cfg_addr_t CFG_SOLAR_OPEN    = 3'd2;
    localparam cfg_addr_t CFG_SAN_MIN_TEMP  = 3'd3;
    localparam cfg_addr_t CFG_SAN_MAX_TEMP  = 3'd4;
    localparam cfg_addr_t CFG_SAN_HOLD_SEC  = 3'd5;
    localparam cfg_addr_t CFG_SAVE_INTERVAL = 3'd6;

    // Packed request payload: last member sits in the lowest bits.
    typedef struct packed {
        logic [TIME_W-1:0]        now_seconds;
        logic signed [TEMP_W-1:0] temperature;
        logic [ADC_BITS-1:0]      sanitize_code;
        logic [ADC_BITS-1:0]      battery_code;
        logic [ADC_BITS-1:0]      solar_code;
    } in_data_t;

    localparam int IN_DATA_W  = $bits(in_data_t);
    localparam int S_TDATA_W  = ((IN_DATA_W + 7) / 8) * 8;

    typedef struct packed {
        in_data_t data;
        logic     temperature_valid;
    } sample_t;

    typedef struct packed {
        logic [LEVEL_W-1:0]       battery_start_level;
        logic [LEVEL_W-1:0]       battery_hold_level;
        logic [LEVEL_W-1:0]       solar_open_level;
        logic signed [TEMP_W-1:0] sanitize_min_temp;
        logic signed [TEMP_W-1:0] sanitize_max_temp;
        logic [HOLD_W-1:0]        sanitize_hold_seconds;
        logic [SAVE_W-1:0]        save_interval_seconds;
    } cfg_t;

    typedef struct packed {
        logic                filled;
        logic [ADC_BITS-1:0] solar_avg;
        logic [ADC_BITS-1:0] battery_avg;
    } avg_t;

    // Packed result payload: vent_open in bit 0.
    typedef struct packed {
        logic [ADC_BITS-1:0] battery_average;
        logic [ADC_BITS-1:0] solar_average;
        logic                log_strobe;
        logic                sanitize_done;
        logic                sanitize_led;
        logic                cooling_on;
        logic                fan_right_drive;
        logic                fan_left_drive;
        logic                fan_run;
        logic                vent_open;
    } res_t;

    localparam int RES_W     = $bits(res_t);
    localparam int M_TDATA_W = ((RES_W + 7) / 8) * 8;

endpackage

### design/solar_kiln_vent_fan_controller.sv
// Top level of the solar kiln vent and fan controller.
// Depends on skv_pkg, skv_cfg, skv_avg and skv_ctrl.
//
//  Channel  | Direction | Handshake          | Payload
//  ---------+-----------+--------------------+--------------------------------------
//  sample   | in        | s_tvalid/s_tready  | s_tdata (codes, temp, time), s_tuser
//  result   | out       | m_tvalid/m_tready  | m_tdata (drives, lamps, averages)
//  config   | in        | cfg_we             | cfg_addr, cfg_wdata
//
// One request per clock, sustained while m_tready takes each result. A request
// waits in the input register, where the averager and the decision logic
// handle it and update their state, and its result then moves into the output
// register, which drives m_tvalid and m_tdata.
// Reset (aresetn low, synchronous) empties both registers and restores the
// register defaults; the sample windows need no clearing.
// A stall on m_tready holds the result; the input register keeps taking
// a request as long as it can move into the output register.
module solar_kiln_vent_fan_controller
    import skv_pkg::*;
#(
    parameter int WINDOW = 5
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    // sample request
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // [9:0] solar_code, [19:10] battery_code, [29:20] sanitize_code,
    // [44:30] temperature, [76:45] now_seconds, [79:77] zero
    input  logic [S_TDATA_W-1:0]  s_tdata,
    // [0] temperature_valid
    input  logic [0:0]            s_tuser,
    // result request
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // [0] vent_open, [1] fan_run, [2] fan_left_drive, [3] fan_right_drive,
    // [4] cooling_on, [5] sanitize_led, [6] sanitize_done, [7] log_strobe,
    // [17:8] solar_average, [27:18] battery_average, [31:28] zero
    output logic [M_TDATA_W-1:0]  m_tdata,
    // configuration write
    input  logic                  cfg_we,
    input  cfg_addr_t             cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_wdata
);

    sample_t sample_reg;
    logic    s_valid_reg;
    res_t    res_reg;
    logic    m_valid_reg;
    logic    step;
    logic    s_load;
    cfg_t    cfg;
    avg_t    avg;
    res_t    res;

    // Advance the held request when the output register is free or draining.
    assign step     = s_valid_reg && (!m_valid_reg || m_tready);
    assign s_tready = !s_valid_reg || step;
    assign s_load   = s_tvalid && s_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s_valid_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            if (s_load) begin
                s_valid_reg <= 1'b1;
            end else if (step) begin
                s_valid_reg <= 1'b0;
            end
            if (step) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers: capture the request on load and the result on step, hold otherwise.
    always_ff @(posedge aclk) begin
        if (s_load) begin
            sample_reg.data              <= s_tdata[IN_DATA_W-1:0];
            sample_reg.temperature_valid <= s_tuser[0];
        end
        if (step) begin
            res_reg <= res;
        end
    end

    skv_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    skv_avg #(
        .WINDOW (WINDOW)
    ) u_avg (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .step         (step),
        .solar_code   (sample_reg.data.solar_code),
        .battery_code (sample_reg.data.battery_code),
        .avg          (avg)
    );

    skv_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step    (step),
        .sample  (sample_reg),
        .avg     (avg),
        .cfg     (cfg),
        .res     (res)
    );

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = M_TDATA_W'(res_reg);

endmodule

### design/skv_cfg.sv
// Configuration register file of the vent and fan controller.
// Depends on skv_pkg for the register indexes and the cfg_t bundle.
module skv_cfg
    import skv_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_we,
    input  cfg_addr_t             cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    output cfg_t                  cfg
);

    cfg_t cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.battery_start_level   <= LEVEL_W'(889);
            cfg_reg.battery_hold_level    <= LEVEL_W'(823);
            cfg_reg.solar_open_level      <= LEVEL_W'(585);
            cfg_reg.sanitize_min_temp     <= TEMP_W'(6000);
            cfg_reg.sanitize_max_temp     <= TEMP_W'(7100);
            cfg_reg.sanitize_hold_seconds <= HOLD_W'(14400);
            cfg_reg.save_interval_seconds <= SAVE_W'(600);
        end else if (cfg_we) begin
            unique case (cfg_addr)
                CFG_BATTERY_START: cfg_reg.battery_start_level   <= cfg_wdata[LEVEL_W-1:0];
                CFG_BATTERY_HOLD:  cfg_reg.battery_hold_level    <= cfg_wdata[LEVEL_W-1:0];
                CFG_SOLAR_OPEN:    cfg_reg.solar_open_level      <= cfg_wdata[LEVEL_W-1:0];
                CFG_SAN_MIN_TEMP:  cfg_reg.sanitize_min_temp     <= cfg_wdata[TEMP_W-1:0];
                CFG_SAN_MAX_TEMP:  cfg_reg.sanitize_max_temp     <= cfg_wdata[TEMP_W-1:0];
                CFG_SAN_HOLD_SEC:  cfg_reg.sanitize_hold_seconds <= cfg_wdata[HOLD_W-1:0];
                CFG_SAVE_INTERVAL: cfg_reg.save_interval_seconds <= cfg_wdata[SAVE_W-1:0];
                default: ;  // drop writes beyond the register list
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

### design/skv_avg.sv
// Moving-average unit: sample windows, running sums and divide by WINDOW.
// Depends on skv_pkg for ADC_BITS and the avg_t bundle.
module skv_avg
    import skv_pkg::*;
#(
    parameter int WINDOW = 5
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                step,
    input  logic [ADC_BITS-1:0] solar_code,
    input  logic [ADC_BITS-1:0] battery_code,
    output avg_t                avg
);

    localparam int SLOT_W  = $clog2(WINDOW);
    localparam int SUM_W   = $clog2(WINDOW * ((1 << ADC_BITS) - 1) + 1);
    localparam int SHIFT   = SUM_W + $clog2(WINDOW);
    localparam int RECIP_W = SUM_W + 1;
    localparam int PROD_W  = SUM_W + RECIP_W;
    // Rounded-up reciprocal; exact quotient for every sum below 2^SUM_W.
    localparam logic [RECIP_W-1:0] RECIP =
        RECIP_W'(((64'd1 << SHIFT) + 64'(WINDOW) - 64'd1) / 64'(WINDOW));

    logic [ADC_BITS-1:0] solar_win_reg   [WINDOW];
    logic [ADC_BITS-1:0] battery_win_reg [WINDOW];
    logic [SUM_W-1:0]    solar_sum_reg,  solar_sum_next;
    logic [SUM_W-1:0]    battery_sum_reg, battery_sum_next;
    logic [SLOT_W-1:0]   slot_reg;
    logic                filled_reg;
    logic [ADC_BITS-1:0] solar_old, battery_old;
    logic [PROD_W-1:0]   solar_prod, battery_prod;
    logic                slot_last;

    assign slot_last   = (slot_reg == SLOT_W'(WINDOW - 1));
    assign solar_old   = filled_reg ? solar_win_reg[slot_reg]   : '0;
    assign battery_old = filled_reg ? battery_win_reg[slot_reg] : '0;

    assign solar_sum_next   = solar_sum_reg - SUM_W'(solar_old) + SUM_W'(solar_code);
    assign battery_sum_next = battery_sum_reg - SUM_W'(battery_old) + SUM_W'(battery_code);

    assign solar_prod   = PROD_W'(solar_sum_next) * PROD_W'(RECIP);
    assign battery_prod = PROD_W'(battery_sum_next) * PROD_W'(RECIP);

    assign avg.filled      = filled_reg;
    assign avg.solar_avg   = solar_prod[SHIFT +: ADC_BITS];
    assign avg.battery_avg = battery_prod[SHIFT +: ADC_BITS];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            solar_sum_reg   <= '0;
            battery_sum_reg <= '0;
            slot_reg        <= '0;
            filled_reg      <= 1'b0;
        end else if (step) begin
            solar_sum_reg   <= solar_sum_next;
            battery_sum_reg <= battery_sum_next;
            if (slot_last) begin
                slot_reg   <= '0;
                filled_reg <= 1'b1;
            end else begin
                slot_reg <= slot_reg + SLOT_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (step) begin
            solar_win_reg[slot_reg]   <= solar_code;
            battery_win_reg[slot_reg] <= battery_code;
        end
    end

endmodule

### design/skv_ctrl.sv
// Vent, fan, sanitize timer and save-interval decision logic.
// Depends on skv_pkg for sample_t, cfg_t, avg_t and res_t.
module skv_ctrl
    import skv_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    step,
    input  sample_t sample,
    input  avg_t    avg,
    input  cfg_t    cfg,
    output res_t    res
);

    logic              run_reg, run_next;
    logic              fan_reg, fan_next;
    logic              vent_reg, vent_next;
    logic              cool_reg, cool_next;
    logic              led_reg, led_next;
    logic              done_reg, done_next;
    logic [TIME_W-1:0] start_reg, start_next;
    logic [TIME_W-1:0] last_save_reg, last_save_next;
    logic              fan_at_save_reg, fan_at_save_next;
    logic              alt_left_reg, alt_left_next;
    logic              alt_right_reg, alt_right_next;
    logic              strobe;

    logic                     temp_ok;
    logic signed [TEMP_W-1:0] temp;
    logic [TIME_W-1:0]        now;
    logic                     sanitize_on;

    assign temp        = sample.data.temperature;
    assign now         = sample.data.now_seconds;
    assign temp_ok     = sample.temperature_valid;
    assign sanitize_on = sample.data.sanitize_code[ADC_BITS-1];

    always_comb begin
        run_next         = run_reg;
        fan_next         = fan_reg;
        vent_next        = vent_reg;
        cool_next        = cool_reg;
        led_next         = led_reg;
        start_next       = start_reg;
        last_save_next   = last_save_reg;
        fan_at_save_next = fan_at_save_reg;
        alt_left_next    = alt_left_reg;
        alt_right_next   = alt_right_reg;

        // restart the timer at or below the floor, then test completion
        if (temp_ok && (temp <= cfg.sanitize_min_temp)) begin
            start_next = now;
        end
        done_next = done_reg ||
                    ((now - start_next) >= TIME_W'(cfg.sanitize_hold_seconds));

        if (avg.filled) begin
            run_next  = sample.data.battery_code[ADC_BITS-1];
            fan_next  = fan_reg ? (avg.battery_avg >= cfg.battery_hold_level)
                                : (avg.battery_avg >= cfg.battery_start_level);
            vent_next = (avg.solar_avg >= cfg.solar_open_level);
            cool_next = vent_next;
            if (sanitize_on) begin
                if (done_next) begin
                    led_next = 1'b1;
                end else if (temp_ok && (temp <= cfg.sanitize_max_temp)) begin
                    vent_next = 1'b0;
                end
            end
        end

        if (!run_next) begin
            vent_next  = 1'b0;
            fan_next   = 1'b0;
            start_next = now;
        end

        strobe = ((now - last_save_reg) > TIME_W'(cfg.save_interval_seconds)) ||
                 (fan_at_save_reg != fan_next);
        if (strobe) begin
            alt_left_next    = alt_right_reg;
            alt_right_next   = alt_left_reg;
            fan_at_save_next = fan_next;
            last_save_next   = now;
        end

        res.vent_open       = vent_next;
        res.fan_run         = fan_next;
        res.fan_left_drive  = fan_next && alt_left_reg;
        res.fan_right_drive = fan_next && alt_right_reg;
        res.cooling_on      = cool_next;
        res.sanitize_led    = led_next;
        res.sanitize_done   = done_next;
        res.log_strobe      = strobe;
        res.solar_average   = avg.solar_avg;
        res.battery_average = avg.battery_avg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_reg         <= 1'b0;
            fan_reg         <= 1'b0;
            vent_reg        <= 1'b0;
            cool_reg        <= 1'b0;
            led_reg         <= 1'b0;
            done_reg        <= 1'b0;
            start_reg       <= '0;
            last_save_reg   <= '0;
            fan_at_save_reg <= 1'b0;
            alt_left_reg    <= 1'b1;
            alt_right_reg   <= 1'b1;
        end else if (step) begin
            run_reg         <= run_next;
            fan_reg         <= fan_next;
            vent_reg        <= vent_next;
            cool_reg        <= cool_next;
            led_reg         <= led_next;
            done_reg        <= done_next;
            start_reg       <= start_next;
            last_save_reg   <= last_save_next;
            fan_at_save_reg <= fan_at_save_next;
            alt_left_reg    <= alt_left_next;
            alt_right_reg   <= alt_right_next;
        end
    end

endmodule

### design/skv_checker.sv
// Port-level checker for the vent and fan controller, bound to the top level.
// Depends on skv_pkg and assert_macros.svh.
`include "assert_macros.svh"

module skv_checker
    import skv_pkg::*;
(
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 s_tready,
    input logic                 m_tvalid,
    input logic                 m_tready,
    input logic [M_TDATA_W-1:0] m_tdata
);

    res_t res;
    logic done_seen_reg;

    assign res = res_t'(m_tdata[RES_W-1:0]);

    // Remember that a delivered result reported sanitize complete.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            done_seen_reg <= 1'b0;
        end else if (m_tvalid && m_tready && res.sanitize_done) begin
            done_seen_reg <= 1'b1;
        end
    end

    `SKV_ASSERT_NXT(a_stall_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "stalled result changed")
    `SKV_ASSERT_NXT_ALWAYS(a_reset_empty, aclk, !aresetn, !m_tvalid, "result valid right after reset")
    `SKV_ASSERT_IMP(a_done_sticky, aclk, aresetn, m_tvalid && done_seen_reg, res.sanitize_done, "sanitize done flag dropped")
    `SKV_ASSERT_IMP(a_ready_when_empty, aclk, aresetn, !m_tvalid, s_tready, "input stalled with empty output")

endmodule

bind solar_kiln_vent_fan_controller skv_checker u_skv_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
